// ===== hw/rtl/eqft_pkg.sv =====
package eqft_pkg;

  localparam int ANGLE_FRAC_BITS = 6;

  localparam int TURN    = 720 << ANGLE_FRAC_BITS;
  localparam int QUARTER = 180 << ANGLE_FRAC_BITS;
  localparam int EIGHTH  = 90 << ANGLE_FRAC_BITS;

  localparam int DEG_TO_RAD_Q30 = 18740330;

  localparam logic [2:0] REG_POS_X = 3'd0;
  localparam logic [2:0] REG_POS_Y = 3'd1;
  localparam logic [2:0] REG_POS_Z = 3'd2;
  localparam logic [2:0] REG_ROT_Z = 3'd3;
  localparam logic [2:0] REG_ROT_X = 3'd4;
  localparam logic [2:0] REG_ROT_Y = 3'd5;

  // Series divisors and their scaled reciprocals floor(2^32 / k).
  localparam logic [7:0]  SIN_K [5] = '{8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
  localparam logic [7:0]  COS_K [5] = '{8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
  localparam logic [31:0] SIN_M [5] = '{32'd39045157, 32'd59652323, 32'd102261126,
                                         32'd214748364, 32'd715827882};
  localparam logic [31:0] COS_M [5] = '{32'd47721858, 32'd76695844, 32'd143165576,
                                         32'd357913941, 32'd2147483648};

  typedef logic signed [29:0] coef_t;
  typedef coef_t [2:0][2:0] mat_t;

endpackage

// ===== hw/rtl/eqft_in_if.sv =====
interface eqft_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] in_x;
  logic signed [31:0] in_y;
  logic signed [31:0] in_z;
  logic               command;
  logic               is_point;

  modport source(output valid, in_x, in_y, in_z, command, is_point, input ready);
  modport sink(input valid, in_x, in_y, in_z, command, is_point, output ready);
endinterface

// ===== hw/rtl/eqft_out_if.sv =====
interface eqft_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;

  modport source(output valid, out_x, out_y, out_z, input ready);
  modport sink(input valid, out_x, out_y, out_z, output ready);
endinterface

// ===== hw/rtl/euler_quaternion_frame_transform_unit.sv =====
// Rigid frame transform of Q16.16 vectors by an object pose. Position and three Euler
// angles (Z, then X, then Y, degrees Q10.6) are written over the APB port; a request
// carries a vector, the direction (0 world to local, 1 local to world) and a point flag.
// Once the rotation matrix is built the unit takes one request per clock and returns
// its result through the offset, product, sum and output registers, saturated to 32
// bits; a stalled output holds the whole pipeline. After reset and after every write
// to an angle register the matrix is rebuilt by one shared multiplier, and requests
// are refused meanwhile.
module euler_quaternion_frame_transform_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  eqft_in_if.sink     req_i,
  eqft_out_if.source  rsp_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
    logic signed [31:0] r;
    if (v > 38'sd2147483647) r = 32'sh7fffffff;
    else if (v < -38'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  logic signed [31:0] pos_q [3];
  logic signed [15:0] rot_q [3];
  logic               wr;
  logic [2:0]         widx;
  logic               restart;

  eqft_pkg::mat_t     mat;
  logic               mat_ok;

  logic               en;
  logic               take;
  logic signed [31:0] in_vec [3];

  logic               v1_q, v2_q, v3_q, v4_q;
  logic               cmd1_q, cmd2_q, cmd3_q;
  logic               pt1_q, pt2_q, pt3_q;
  logic signed [32:0] vec1_q [3];
  logic signed [62:0] prod2_q [3][3];
  logic signed [36:0] sum3_q [3];
  logic signed [31:0] out4_q [3];

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign widx   = paddr[4:2];
  assign restart = wr && (widx == eqft_pkg::REG_ROT_Z || widx == eqft_pkg::REG_ROT_X ||
                          widx == eqft_pkg::REG_ROT_Y);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '{default: '0};
      rot_q <= '{default: '0};
    end else if (wr) begin
      unique case (widx)
        eqft_pkg::REG_POS_X: pos_q[0] <= pwdata;
        eqft_pkg::REG_POS_Y: pos_q[1] <= pwdata;
        eqft_pkg::REG_POS_Z: pos_q[2] <= pwdata;
        eqft_pkg::REG_ROT_Z: rot_q[0] <= pwdata[15:0];
        eqft_pkg::REG_ROT_X: rot_q[1] <= pwdata[15:0];
        eqft_pkg::REG_ROT_Y: rot_q[2] <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      eqft_pkg::REG_POS_X: prdata = pos_q[0];
      eqft_pkg::REG_POS_Y: prdata = pos_q[1];
      eqft_pkg::REG_POS_Z: prdata = pos_q[2];
      eqft_pkg::REG_ROT_Z: prdata = {16'b0, rot_q[0]};
      eqft_pkg::REG_ROT_X: prdata = {16'b0, rot_q[1]};
      eqft_pkg::REG_ROT_Y: prdata = {16'b0, rot_q[2]};
      default:             prdata = '0;
    endcase
  end

  eqft_rot_build u_rot_build (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (restart),
    .rot_z_i   (rot_q[0]),
    .rot_x_i   (rot_q[1]),
    .rot_y_i   (rot_q[2]),
    .mat_o     (mat),
    .mat_ok_o  (mat_ok)
  );

  assign en          = !v4_q || rsp_o.ready;
  assign req_i.ready = en && mat_ok;
  assign take        = req_i.valid && req_i.ready;
  assign in_vec[0]   = req_i.in_x;
  assign in_vec[1]   = req_i.in_y;
  assign in_vec[2]   = req_i.in_z;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= take;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cmd1_q <= req_i.command;
      pt1_q  <= req_i.is_point;
      cmd2_q <= cmd1_q;
      pt2_q  <= pt1_q;
      cmd3_q <= cmd2_q;
      pt3_q  <= pt2_q;
      for (int i = 0; i < 3; i++) begin
        if (!req_i.command && req_i.is_point) begin
          vec1_q[i] <= 33'(in_vec[i]) - 33'(pos_q[i]);
        end else begin
          vec1_q[i] <= 33'(in_vec[i]);
        end
        for (int j = 0; j < 3; j++) begin
          prod2_q[i][j] <= (cmd1_q ? mat[i][j] : mat[j][i]) * vec1_q[j];
        end
        sum3_q[i] <= 37'((65'(prod2_q[i][0]) + 65'(prod2_q[i][1]) + 65'(prod2_q[i][2])
                          + 65'sd134217728) >>> 28);
        out4_q[i] <= sat32(38'(sum3_q[i]) + ((cmd3_q && pt3_q) ? 38'(pos_q[i]) : 38'sd0));
      end
    end
  end

  assign rsp_o.valid = v4_q;
  assign rsp_o.out_x = out4_q[0];
  assign rsp_o.out_y = out4_q[1];
  assign rsp_o.out_z = out4_q[2];

endmodule

// ===== hw/rtl/eqft_rot_build.sv =====
module eqft_rot_build (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                restart_i,
  input  logic signed [15:0]  rot_z_i,
  input  logic signed [15:0]  rot_x_i,
  input  logic signed [15:0]  rot_y_i,
  output eqft_pkg::mat_t      mat_o,
  output logic                mat_ok_o
);

  typedef enum logic [8:0] {
    PH_IDLE   = 9'b000000001,
    PH_PREP   = 9'b000000010,
    PH_XRAD   = 9'b000000100,
    PH_XSQ    = 9'b000001000,
    PH_SERIES = 9'b000010000,
    PH_SINE   = 9'b000100000,
    PH_QUAT   = 9'b001000000,
    PH_MPROD  = 9'b010000000,
    PH_MENTRY = 9'b100000000
  } phase_e;

  localparam logic [2:0] SUB_LAST  = 3'd5;
  localparam logic [2:0] ITER_LAST = 3'd4;
  localparam logic [1:0] ANG_LAST  = 2'd2;
  localparam logic [3:0] QUAT_LAST = 4'd11;
  localparam logic [3:0] PROD_LAST = 4'd8;
  localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;

  function automatic logic signed [31:0] rnd30(input logic signed [65:0] v);
    logic signed [65:0] t;
    t = (v + 66'sd536870912) >>> 30;
    return t[31:0];
  endfunction

  function automatic logic signed [31:0] clamp01(input logic signed [31:0] v);
    logic signed [31:0] r;
    r = v;
    if (v < 0) r = '0;
    if (v > ONE_Q30) r = ONE_Q30;
    return r;
  endfunction

  function automatic eqft_pkg::coef_t to_q28(input logic signed [65:0] v);
    logic signed [65:0] t;
    t = (v + 66'sd2147483648) >>> 32;
    if (t > 66'sd268435456) t = 66'sd268435456;
    if (t < -66'sd268435456) t = -66'sd268435456;
    return t[29:0];
  endfunction

  phase_e      phase_q;
  logic        half_q;
  logic [1:0]  ang_q;
  logic [2:0]  iter_q;
  logic [2:0]  sub_q;
  logic [3:0]  idx_q;
  logic        mat_ok_q;

  logic [13:0]        r_q;
  logic [1:0]         k_q;
  logic               fold_q;
  logic signed [31:0] x_q, x2_q, ts_q, tc_q, m_q, q0_q;
  logic signed [31:0] s_q [3];
  logic signed [31:0] c_q [3];
  logic signed [31:0] t_q [4];
  logic signed [31:0] qv_q [4];
  logic signed [65:0] acc_q;
  logic signed [63:0] pr_q [9];
  logic signed [65:0] p_q;
  eqft_pkg::mat_t     mat_q;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;

  logic signed [15:0] raw;
  logic signed [17:0] hs;
  logic [15:0]        h;
  logic [1:0]         kk;
  logic [15:0]        rr;
  logic               fold;
  logic [13:0]        rfold;

  logic [7:0]         div_k;
  logic [31:0]        div_m;
  logic [31:0]        rem;
  logic signed [31:0] qfix;

  logic signed [31:0] s_cl, c_cl, s_f, c_f, s_out, c_out;
  logic [3:0]         jj;

  assign mat_o    = mat_q;
  assign mat_ok_o = mat_ok_q;

  // Angle reduction to one turn, quadrant and fold.
  always_comb begin
    unique case (ang_q)
      2'd0:    raw = rot_z_i;
      2'd1:    raw = rot_x_i;
      default: raw = rot_y_i;
    endcase
    hs = 18'(raw) + ((raw < 0) ? 18'(eqft_pkg::TURN) : 18'sd0);
    h  = hs[15:0];
    if (h >= 16'(3 * eqft_pkg::QUARTER)) begin
      kk = 2'd3;
      rr = h - 16'(3 * eqft_pkg::QUARTER);
    end else if (h >= 16'(2 * eqft_pkg::QUARTER)) begin
      kk = 2'd2;
      rr = h - 16'(2 * eqft_pkg::QUARTER);
    end else if (h >= 16'(eqft_pkg::QUARTER)) begin
      kk = 2'd1;
      rr = h - 16'(eqft_pkg::QUARTER);
    end else begin
      kk = 2'd0;
      rr = h;
    end
    fold  = rr > 16'(eqft_pkg::EIGHTH);
    rfold = fold ? 14'(16'(eqft_pkg::QUARTER) - rr) : rr[13:0];
  end

  always_comb begin
    if (sub_q < 3'd3) begin
      div_k = eqft_pkg::SIN_K[iter_q];
      div_m = eqft_pkg::SIN_M[iter_q];
    end else begin
      div_k = eqft_pkg::COS_K[iter_q];
      div_m = eqft_pkg::COS_M[iter_q];
    end
    rem  = m_q - p_q[31:0];
    qfix = (rem >= 32'(div_k)) ? q0_q + 32'sd1 : q0_q;
  end

  assign jj = idx_q - 4'd4;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (phase_q)
      PH_XRAD: begin
        mul_a = 33'(r_q);
        mul_b = 33'(eqft_pkg::DEG_TO_RAD_Q30);
      end
      PH_XSQ: begin
        mul_a = 33'(x_q);
        mul_b = 33'(x_q);
      end
      PH_SERIES: begin
        unique case (sub_q)
          3'd0:    begin mul_a = 33'(x2_q); mul_b = 33'(ts_q);  end
          3'd3:    begin mul_a = 33'(x2_q); mul_b = 33'(tc_q);  end
          3'd1,
          3'd4:    begin mul_a = 33'(m_q);  mul_b = 33'(div_m); end
          default: begin mul_a = 33'(q0_q); mul_b = 33'(div_k); end
        endcase
      end
      PH_SINE: begin
        mul_a = 33'(x_q);
        mul_b = 33'(ts_q);
      end
      PH_QUAT: begin
        unique case (idx_q)
          4'd0:    begin mul_a = 33'(c_q[0]); mul_b = 33'(c_q[1]); end
          4'd1:    begin mul_a = 33'(c_q[0]); mul_b = 33'(s_q[1]); end
          4'd2:    begin mul_a = 33'(s_q[0]); mul_b = 33'(s_q[1]); end
          4'd3:    begin mul_a = 33'(s_q[0]); mul_b = 33'(c_q[1]); end
          4'd4:    begin mul_a = 33'(t_q[0]); mul_b = 33'(c_q[2]); end
          4'd5:    begin mul_a = 33'(t_q[2]); mul_b = 33'(s_q[2]); end
          4'd6:    begin mul_a = 33'(t_q[1]); mul_b = 33'(c_q[2]); end
          4'd7:    begin mul_a = 33'(t_q[3]); mul_b = 33'(s_q[2]); end
          4'd8:    begin mul_a = 33'(t_q[0]); mul_b = 33'(s_q[2]); end
          4'd9:    begin mul_a = 33'(t_q[2]); mul_b = 33'(c_q[2]); end
          4'd10:   begin mul_a = 33'(t_q[1]); mul_b = 33'(s_q[2]); end
          default: begin mul_a = 33'(t_q[3]); mul_b = 33'(c_q[2]); end
        endcase
      end
      PH_MPROD: begin
        unique case (idx_q)
          4'd0:    begin mul_a = 33'(qv_q[1]); mul_b = 33'(qv_q[1]); end
          4'd1:    begin mul_a = 33'(qv_q[2]); mul_b = 33'(qv_q[2]); end
          4'd2:    begin mul_a = 33'(qv_q[3]); mul_b = 33'(qv_q[3]); end
          4'd3:    begin mul_a = 33'(qv_q[1]); mul_b = 33'(qv_q[2]); end
          4'd4:    begin mul_a = 33'(qv_q[0]); mul_b = 33'(qv_q[3]); end
          4'd5:    begin mul_a = 33'(qv_q[1]); mul_b = 33'(qv_q[3]); end
          4'd6:    begin mul_a = 33'(qv_q[0]); mul_b = 33'(qv_q[2]); end
          4'd7:    begin mul_a = 33'(qv_q[2]); mul_b = 33'(qv_q[3]); end
          default: begin mul_a = 33'(qv_q[0]); mul_b = 33'(qv_q[1]); end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    s_cl = clamp01(rnd30(p_q));
    c_cl = clamp01(tc_q);
    s_f  = fold_q ? c_cl : s_cl;
    c_f  = fold_q ? s_cl : c_cl;
    unique case (k_q)
      2'd0:    begin c_out = c_f;  s_out = s_f;  end
      2'd1:    begin c_out = -s_f; s_out = c_f;  end
      2'd2:    begin c_out = -c_f; s_out = -s_f; end
      default: begin c_out = s_f;  s_out = -c_f; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      half_q   <= 1'b0;
      ang_q    <= '0;
      iter_q   <= '0;
      sub_q    <= '0;
      idx_q    <= '0;
      mat_ok_q <= 1'b0;
    end else if (restart_i) begin
      phase_q  <= PH_IDLE;
      half_q   <= 1'b0;
      mat_ok_q <= 1'b0;
    end else begin
      unique case (phase_q)
        PH_IDLE: begin
          if (!mat_ok_q) begin
            phase_q <= PH_PREP;
            ang_q   <= '0;
          end
        end
        PH_PREP: begin
          phase_q <= PH_XRAD;
          half_q  <= 1'b0;
        end
        PH_XRAD: begin
          half_q <= ~half_q;
          if (half_q) phase_q <= PH_XSQ;
        end
        PH_XSQ: begin
          half_q <= ~half_q;
          if (half_q) begin
            phase_q <= PH_SERIES;
            iter_q  <= '0;
            sub_q   <= '0;
          end
        end
        PH_SERIES: begin
          half_q <= ~half_q;
          if (half_q) begin
            if (sub_q == SUB_LAST) begin
              sub_q <= '0;
              if (iter_q == ITER_LAST) phase_q <= PH_SINE;
              else iter_q <= iter_q + 3'd1;
            end else begin
              sub_q <= sub_q + 3'd1;
            end
          end
        end
        PH_SINE: begin
          half_q <= ~half_q;
          if (half_q) begin
            if (ang_q == ANG_LAST) begin
              phase_q <= PH_QUAT;
              idx_q   <= '0;
            end else begin
              ang_q   <= ang_q + 2'd1;
              phase_q <= PH_PREP;
            end
          end
        end
        PH_QUAT: begin
          half_q <= ~half_q;
          if (half_q) begin
            if (idx_q == QUAT_LAST) begin
              phase_q <= PH_MPROD;
              idx_q   <= '0;
            end else begin
              idx_q <= idx_q + 4'd1;
            end
          end
        end
        PH_MPROD: begin
          half_q <= ~half_q;
          if (half_q) begin
            if (idx_q == PROD_LAST) phase_q <= PH_MENTRY;
            else idx_q <= idx_q + 4'd1;
          end
        end
        PH_MENTRY: begin
          mat_ok_q <= 1'b1;
          phase_q  <= PH_IDLE;
        end
        default: phase_q <= PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= prod;
    unique case (phase_q)
      PH_PREP: begin
        r_q    <= rfold;
        k_q    <= kk;
        fold_q <= fold;
      end
      PH_XRAD: begin
        if (half_q) begin
          x_q <= 32'((p_q + (66'sd1 <<< eqft_pkg::ANGLE_FRAC_BITS))
                     >>> (eqft_pkg::ANGLE_FRAC_BITS + 1));
        end
      end
      PH_XSQ: begin
        if (half_q) begin
          x2_q <= rnd30(p_q);
          ts_q <= ONE_Q30;
          tc_q <= ONE_Q30;
        end
      end
      PH_SERIES: begin
        if (half_q) begin
          unique case (sub_q)
            3'd0, 3'd3: m_q  <= rnd30(p_q);
            3'd1, 3'd4: q0_q <= 32'(p_q >>> 32);
            3'd2:       ts_q <= ONE_Q30 - qfix;
            default:    tc_q <= ONE_Q30 - qfix;
          endcase
        end
      end
      PH_SINE: begin
        if (half_q) begin
          s_q[ang_q] <= s_out;
          c_q[ang_q] <= c_out;
        end
      end
      PH_QUAT: begin
        if (half_q) begin
          if (idx_q < 4'd4) begin
            t_q[idx_q[1:0]] <= rnd30(p_q);
          end else if (!jj[0]) begin
            acc_q <= p_q;
          end else if (jj[2:1] < 2'd2) begin
            qv_q[jj[2:1]] <= rnd30(acc_q - p_q);
          end else begin
            qv_q[jj[2:1]] <= rnd30(acc_q + p_q);
          end
        end
      end
      PH_MPROD: begin
        if (half_q) pr_q[idx_q] <= p_q[63:0];
      end
      PH_MENTRY: begin
        mat_q[0][0] <= to_q28((66'sd1 <<< 60) - ((66'(pr_q[1]) + 66'(pr_q[2])) <<< 1));
        mat_q[0][1] <= to_q28((66'(pr_q[3]) - 66'(pr_q[4])) <<< 1);
        mat_q[0][2] <= to_q28((66'(pr_q[5]) + 66'(pr_q[6])) <<< 1);
        mat_q[1][0] <= to_q28((66'(pr_q[3]) + 66'(pr_q[4])) <<< 1);
        mat_q[1][1] <= to_q28((66'sd1 <<< 60) - ((66'(pr_q[0]) + 66'(pr_q[2])) <<< 1));
        mat_q[1][2] <= to_q28((66'(pr_q[7]) - 66'(pr_q[8])) <<< 1);
        mat_q[2][0] <= to_q28((66'(pr_q[5]) - 66'(pr_q[6])) <<< 1);
        mat_q[2][1] <= to_q28((66'(pr_q[7]) + 66'(pr_q[8])) <<< 1);
        mat_q[2][2] <= to_q28((66'sd1 <<< 60) - ((66'(pr_q[0]) + 66'(pr_q[1])) <<< 1));
      end
      default: begin
      end
    endcase
  end

endmodule
